[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the record store.
// Expects clk_i and rst_ni to exist in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define RSXS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a trigger implies a consequence in the next cycle.
`define RSXS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rsxs_pkg.sv]
// Shared types and constants of the record store with exchange sort.
// No dependencies; used by the top level.
`default_nettype none

package rsxs_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned REC_W    = PRICE_W + ID_W;
  localparam int unsigned LIMIT_RESET = 16;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_SORT = 2'd1,
    ACT_DUMP = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    KIND_ADDED  = 3'd0,
    KIND_FULL   = 3'd1,
    KIND_SORTED = 3'd2,
    KIND_RECORD = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_LOAD,
    ST_SORT_SCAN,
    ST_SORT_PLACE,
    ST_SORT_DONE,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [PRICE_W-1:0] item_price;
    logic [ID_W-1:0]    item_id;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [PRICE_W-1:0] out_price;
    logic [ID_W-1:0]    out_id;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } record_t;

endpackage

`default_nettype wire

[rtl/core/rsxs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rsxs_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/record_store_exchange_sort_top.sv]
// Record store with exchange sort: top level, sequencer and datapath.
// Depends on rsxs_pkg, rsxs_ram and assert_macros.svh.
`default_nettype none

// The block keeps up to CAPACITY records (32-bit 24.8 price, 16-bit id) in a
// small RAM with one write and one registered read port. An add transaction
// answers in the cycle after acceptance with "added" or "full"; the limit is
// the limit_q register, clipped to CAPACITY. A sort transaction runs
// exchange sort through one shared price comparator: the record of slot i
// sits in a holding register while slots i+1..n-1 stream past it, one read per
// cycle, and a smaller price swaps places with it. A sort ends in one
// "sorted" transaction. A dump emits n record transactions, one per cycle
// when the output is not stalled, with last on the final one, or a single
// "empty" transaction. Input stays stalled while a sort or dump runs.
// Results pass through one output register, so a new input is taken while
// the previous result is being taken. Action code 3 is dropped without a
// result.
module record_store_exchange_sort_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire rsxs_pkg::req_t            in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output rsxs_pkg::rsp_t                 out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [rsxs_pkg::CNT_W-1:0] cfg_data_i
);

  rsxs_pkg::state_e                 state_q, state_d;
  logic [rsxs_pkg::CNT_W-1:0]       count_q;
  logic [rsxs_pkg::CNT_W-1:0]       limit_q;
  logic [rsxs_pkg::CNT_W-1:0]       eff_limit;
  logic [rsxs_pkg::SLOT_W-1:0]      i_q, j_q, k_q;
  rsxs_pkg::record_t                hold_q;
  rsxs_pkg::record_t                rd_rec;
  logic [rsxs_pkg::REC_W-1:0]       ram_rdata;
  rsxs_pkg::rsp_t                   out_q, out_d;
  logic                             out_valid_q;

  logic                             can_load;
  logic                             in_acc;
  logic                             add_ok;
  logic                             price_less;
  logic [rsxs_pkg::CNT_W-1:0]       j_next, i_next2, k_next;
  logic                             scan_more, place_more, dump_last;

  logic                             ram_we, ram_re;
  logic [rsxs_pkg::SLOT_W-1:0]      ram_waddr, ram_raddr;
  rsxs_pkg::record_t                ram_wdata;
  logic                             load_out;

  // The user must write configuration only while idle; not enforced, always taken.
  assign cfg_ready_o = 1'b1;

  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == rsxs_pkg::ST_IDLE) && can_load);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign eff_limit = (limit_q > rsxs_pkg::CNT_W'(rsxs_pkg::CAPACITY)) ?
                     rsxs_pkg::CNT_W'(rsxs_pkg::CAPACITY) : limit_q;
  assign add_ok    = count_q < eff_limit;

  assign rd_rec     = rsxs_pkg::record_t'(ram_rdata);
  // Shared compare unit: streamed record against the held one.
  assign price_less = rd_rec.price < hold_q.price;

  assign j_next     = {1'b0, j_q} + rsxs_pkg::CNT_W'(1);
  assign i_next2    = {1'b0, i_q} + rsxs_pkg::CNT_W'(2);
  assign k_next     = {1'b0, k_q} + rsxs_pkg::CNT_W'(1);
  assign scan_more  = j_next < count_q;
  assign place_more = i_next2 < count_q;
  assign dump_last  = k_next == count_q;

  rsxs_ram #(
    .Width (rsxs_pkg::REC_W),
    .Depth (rsxs_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsxs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((in_data_i.action == rsxs_pkg::ACT_SORT) &&
              (count_q >= rsxs_pkg::CNT_W'(2))) begin
            state_d = rsxs_pkg::ST_SORT_LOAD;
          end else if ((in_data_i.action == rsxs_pkg::ACT_DUMP) &&
                       (count_q != '0)) begin
            state_d = rsxs_pkg::ST_DUMP;
          end
        end
      end
      rsxs_pkg::ST_SORT_LOAD: state_d = rsxs_pkg::ST_SORT_SCAN;
      rsxs_pkg::ST_SORT_SCAN: begin
        if (!scan_more) begin
          state_d = rsxs_pkg::ST_SORT_PLACE;
        end
      end
      rsxs_pkg::ST_SORT_PLACE: begin
        state_d = place_more ? rsxs_pkg::ST_SORT_LOAD : rsxs_pkg::ST_SORT_DONE;
      end
      rsxs_pkg::ST_SORT_DONE: begin
        if (can_load) begin
          state_d = rsxs_pkg::ST_IDLE;
        end
      end
      rsxs_pkg::ST_DUMP: begin
        if (can_load && dump_last) begin
          state_d = rsxs_pkg::ST_IDLE;
        end
      end
      default: state_d = rsxs_pkg::ST_IDLE;
    endcase
  end

  // Output logic: RAM port control and result register load.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = hold_q;
    ram_re    = 1'b0;
    ram_raddr = j_q;
    load_out  = 1'b0;
    out_d     = '0;
    out_d.last = 1'b1;
    unique case (state_q)
      rsxs_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.action)
            rsxs_pkg::ACT_ADD: begin
              load_out = 1'b1;
              if (add_ok) begin
                ram_we          = 1'b1;
                ram_waddr       = count_q[rsxs_pkg::SLOT_W-1:0];
                ram_wdata.price = in_data_i.item_price;
                ram_wdata.id    = in_data_i.item_id;
                out_d.kind      = rsxs_pkg::KIND_ADDED;
                out_d.out_price = in_data_i.item_price;
                out_d.out_id    = in_data_i.item_id;
                out_d.slot      = count_q[rsxs_pkg::SLOT_W-1:0];
              end else begin
                out_d.kind = rsxs_pkg::KIND_FULL;
              end
            end
            rsxs_pkg::ACT_SORT: begin
              if (count_q >= rsxs_pkg::CNT_W'(2)) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
              end else begin
                load_out   = 1'b1;
                out_d.kind = rsxs_pkg::KIND_SORTED;
              end
            end
            rsxs_pkg::ACT_DUMP: begin
              if (count_q != '0) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
              end else begin
                load_out   = 1'b1;
                out_d.kind = rsxs_pkg::KIND_EMPTY;
              end
            end
            default: begin
              // Drop the reserved action.
            end
          endcase
        end
      end
      rsxs_pkg::ST_SORT_LOAD: begin
        ram_re    = 1'b1;
        ram_raddr = j_q;
      end
      rsxs_pkg::ST_SORT_SCAN: begin
        if (price_less) begin
          ram_we    = 1'b1;
          ram_waddr = j_q;
          ram_wdata = hold_q;
        end
        if (scan_more) begin
          ram_re    = 1'b1;
          ram_raddr = j_next[rsxs_pkg::SLOT_W-1:0];
        end
      end
      rsxs_pkg::ST_SORT_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = hold_q;
        if (place_more) begin
          ram_re    = 1'b1;
          ram_raddr = i_q + rsxs_pkg::SLOT_W'(1);
        end
      end
      rsxs_pkg::ST_SORT_DONE: begin
        load_out   = can_load;
        out_d.kind = rsxs_pkg::KIND_SORTED;
      end
      rsxs_pkg::ST_DUMP: begin
        load_out        = can_load;
        out_d.kind      = rsxs_pkg::KIND_RECORD;
        out_d.out_price = rd_rec.price;
        out_d.out_id    = rd_rec.id;
        out_d.slot      = k_q;
        out_d.last      = dump_last;
        if (can_load && !dump_last) begin
          ram_re    = 1'b1;
          ram_raddr = k_next[rsxs_pkg::SLOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsxs_pkg::ST_IDLE;
      count_q     <= '0;
      limit_q     <= rsxs_pkg::CNT_W'(rsxs_pkg::LIMIT_RESET);
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (in_acc && (in_data_i.action == rsxs_pkg::ACT_ADD) && add_ok) begin
        count_q <= count_q + rsxs_pkg::CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Advance the sort and dump indexes.
      priority if (state_q == rsxs_pkg::ST_IDLE) begin
        i_q <= '0;
        j_q <= rsxs_pkg::SLOT_W'(1);
        k_q <= '0;
      end else if ((state_q == rsxs_pkg::ST_SORT_SCAN) && scan_more) begin
        j_q <= j_next[rsxs_pkg::SLOT_W-1:0];
      end else if (state_q == rsxs_pkg::ST_SORT_PLACE) begin
        i_q <= i_q + rsxs_pkg::SLOT_W'(1);
        j_q <= i_next2[rsxs_pkg::SLOT_W-1:0];
      end else if ((state_q == rsxs_pkg::ST_DUMP) && can_load && !dump_last) begin
        k_q <= k_next[rsxs_pkg::SLOT_W-1:0];
      end else begin
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
    if ((state_q == rsxs_pkg::ST_SORT_LOAD) ||
        ((state_q == rsxs_pkg::ST_SORT_SCAN) && price_less)) begin
      hold_q <= rd_rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "assert_macros.svh"

  // The fill count never passes the store size.
  `RSXS_ASSERT(a_count_bound, count_q <= rsxs_pkg::CNT_W'(rsxs_pkg::CAPACITY), "count overflow")
  // A write and a read in one cycle never hit the same slot.
  `RSXS_ASSERT(a_no_rw_clash, !(ram_we && ram_re && (ram_waddr == ram_raddr)), "RAM clash")
  // The fill count holds across every cycle spent outside idle.
  `RSXS_ASSERT_NEXT(a_count_stable, state_q != rsxs_pkg::ST_IDLE, $stable(count_q), "count moved")

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for record_store_exchange_sort_top: the record store,
// its exchange sort and its dump, against a predictor kept in this file.
// Depends on rsxs_pkg and the RTL of the top level; reads no files.
`default_nettype none

module tb_top;
  import rsxs_pkg::*;

  // Action code 3 has no meaning; the block must drop it without a result.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Cycles to let pass once the last result is in. The longest work that can
  // end without a result is an unused action, which the block drops at once.
  localparam int SETTLE_CYCLES  = 20;
  // Long enough to span a full sort, or a full dump with output stalls.
  localparam int QUIET_LIMIT    = 2000;
  localparam int MAX_ERR_LINES  = 40;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  req_t                 in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  rsp_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CNT_W-1:0]     cfg_data_i = '0;

  record_store_exchange_sort_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  req_t             action_backlog[$];   // requests not yet driven
  rsp_t             due_results[$];      // results the block still owes, oldest first
  bit               idle_on = 1'b1;      // random gaps and stalls allowed
  bit               in_taken = 1'b0;     // request transaction at the last rising edge
  int               in_gap = 0;
  int               stall_left = 0;
  int               quiet_cycles = 0;
  int               error_count = 0;

  // Predictor copy of the store and its limit register.
  record_t          shadow_store[CAPACITY];
  int unsigned      stored_count = 0;
  logic [CNT_W-1:0] limit_reg = CNT_W'(LIMIT_RESET);

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_ERR_LINES)
      $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic rsp_t make_rsp(kind_e k, logic [PRICE_W-1:0] p, logic [ID_W-1:0] id,
                                    logic [SLOT_W-1:0] s, logic lst);
    rsp_t r;
    r.kind      = k;
    r.out_price = p;
    r.out_id    = id;
    r.slot      = s;
    r.last      = lst;
    return r;
  endfunction

  // Apply one accepted request to the shadow store and queue what it must emit.
  task automatic predict_store_action(input req_t req);
    int unsigned lim;
    record_t     tmp;
    // Clip the limit register to the physical size of the store.
    lim = (limit_reg > CAPACITY) ? CAPACITY : limit_reg;
    case (req.action)
      ACT_ADD: begin
        if (stored_count < lim) begin
          shadow_store[stored_count].price = req.item_price;
          shadow_store[stored_count].id    = req.item_id;
          due_results.push_back(make_rsp(KIND_ADDED, req.item_price, req.item_id,
                                         SLOT_W'(stored_count), 1'b1));
          stored_count++;
        end else begin
          due_results.push_back(make_rsp(KIND_FULL, '0, '0, '0, 1'b1));
        end
      end
      ACT_SORT: begin
        // Exchange sort: hold slot i, swap in any later slot with a strictly
        // smaller price.
        for (int unsigned i = 0; i + 1 < stored_count; i++) begin
          for (int unsigned j = i + 1; j < stored_count; j++) begin
            if (shadow_store[j].price < shadow_store[i].price) begin
              tmp             = shadow_store[i];
              shadow_store[i] = shadow_store[j];
              shadow_store[j] = tmp;
            end
          end
        end
        due_results.push_back(make_rsp(KIND_SORTED, '0, '0, '0, 1'b1));
      end
      ACT_DUMP: begin
        if (stored_count == 0) begin
          due_results.push_back(make_rsp(KIND_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          for (int unsigned i = 0; i < stored_count; i++)
            due_results.push_back(make_rsp(KIND_RECORD, shadow_store[i].price,
                                           shadow_store[i].id, SLOT_W'(i),
                                           (i + 1 == stored_count)));
        end
      end
      default: ; // drop the unused code, nothing is emitted
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: advance on the falling edge once the held transaction is gone
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (action_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          // Open an idle burst: drop valid and draw a random gap count.
          in_valid_i <= 1'b0;
          in_gap     <= $urandom_range(0, 12);
        end else begin
          in_data_i  <= action_backlog.pop_front();
          in_valid_i <= 1'b1;
        end
      end
      // Otherwise hold valid and payload until the block takes them.
    end
  end

  // Result-side back-pressure in bursts of stalled cycles of random length.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, check results, predict, watch for hangs
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    bit   in_fire;
    bit   out_fire;
    bit   cfg_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    cfg_fire = rst_ni && cfg_valid_i && cfg_ready_o;
    in_taken <= in_fire;

    // Check the result transaction against the oldest expectation first;
    // a request taken at this same edge cannot have produced it yet.
    if (out_fire) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d", out_data_o.kind));
      end else begin
        want = due_results.pop_front();
        if (out_data_o.kind !== want.kind)
          flag_error($sformatf("kind got %0d want %0d", out_data_o.kind, want.kind));
        if (out_data_o.out_price !== want.out_price)
          flag_error($sformatf("price got %h want %h", out_data_o.out_price,
                               want.out_price));
        if (out_data_o.out_id !== want.out_id)
          flag_error($sformatf("id got %h want %h", out_data_o.out_id, want.out_id));
        if (out_data_o.slot !== want.slot)
          flag_error($sformatf("slot got %0d want %0d", out_data_o.slot, want.slot));
        if (out_data_o.last !== want.last)
          flag_error($sformatf("last got %b want %b", out_data_o.last, want.last));
      end
    end

    if (cfg_fire)
      limit_reg = cfg_data_i;
    if (in_fire)
      predict_store_action(in_data_i);

    // Watchdog: end the run when nothing moves on any channel for too long.
    if (in_fire || out_fire || cfg_fire || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] act, input logic [PRICE_W-1:0] price,
                            input logic [ID_W-1:0] id);
    req_t r;
    r.action     = act;
    r.item_price = price;
    r.item_id    = id;
    action_backlog.push_back(r);
  endtask

  // Queue n random requests; dropped codes ride along but do not count.
  task automatic queue_random(input int n);
    int                 done;
    int unsigned        pick;
    logic [PRICE_W-1:0] price;
    done = 0;
    while (done < n) begin
      // Mix wide prices with a narrow range that produces equal keys.
      case ($urandom_range(0, 3))
        0:       price = $urandom_range(0, 7);
        1:       price = ($urandom_range(0, 1) != 0) ? '1 : '0;
        default: price = $urandom;
      endcase
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        queue_item(ACT_ADD, price, ID_W'($urandom_range(0, 65535)));
        done++;
      end else if (pick <= 6) begin
        queue_item(ACT_SORT, price, ID_W'($urandom_range(0, 65535)));
        done++;
      end else if (pick <= 8) begin
        queue_item(ACT_DUMP, price, ID_W'($urandom_range(0, 65535)));
        done++;
      end else begin
        queue_item(ACT_UNUSED, price, ID_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  // Wait until every request is taken and every result is in, then let the
  // block come to rest.
  task automatic drain_and_settle();
    while (action_backlog.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Limit zero: empty dump and sort, an add that must report full, a
    // dropped code.
    write_limit(5'd0);
    queue_item(ACT_DUMP, 32'h0, 16'h0);
    queue_item(ACT_SORT, 32'h0, 16'h0);
    queue_item(ACT_ADD, 32'h1234_5600, 16'hBEEF);
    queue_item(ACT_UNUSED, '1, '1);
    drain_and_settle();

    // Limit two: sort of a single record, extreme fields, full at the limit.
    write_limit(5'd2);
    queue_item(ACT_ADD, 32'h0, 16'h0);
    queue_item(ACT_SORT, 32'h0, 16'h0);
    queue_item(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    queue_item(ACT_ADD, 32'h0000_0100, 16'h0001);
    queue_item(ACT_SORT, 32'h0, 16'h0);
    queue_item(ACT_DUMP, 32'h0, 16'h0);
    drain_and_settle();

    // Limit above the store size saturates; equal prices and a descending run.
    write_limit(5'd31);
    queue_item(ACT_ADD, 32'h0000_0180, 16'h00A1);
    queue_item(ACT_ADD, 32'h0000_0180, 16'h00A2);
    queue_item(ACT_ADD, 32'h0000_0001, 16'h5555);
    queue_item(ACT_ADD, 32'h8000_0000, 16'hAAAA);
    queue_item(ACT_SORT, 32'h0, 16'h0);
    queue_item(ACT_DUMP, 32'h0, 16'h0);
    drain_and_settle();

    // Random traffic: fill part of the store under a mid limit, then the rest.
    write_limit(5'd9);
    queue_random(28);
    drain_and_settle();

    write_limit(5'd31);
    queue_random(28);
    drain_and_settle();

    // Limit below the count: adds report full, dumps still show every record.
    write_limit(5'd5);
    queue_random(24);
    drain_and_settle();

    // Last stretch at the reset limit with no gaps and no stalls.
    idle_on = 1'b0;
    write_limit(5'd16);
    queue_random(24);
    drain_and_settle();

    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
